// ----- hdl/prv_pkg.sv -----
`default_nettype none

package prv_pkg;

    // Record format and limits.
    localparam logic [15:0] MAX_PAGE_BYTES  = 16'd1024;
    localparam logic [15:0] PAGE_SIZE_RESET = 16'd1024;
    localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
    localparam logic [31:0] SEQ_LAST        = 32'hFFFF_FFFE;

    // Byte position counter of a stream, saturating at its maximum.
    localparam int POS_W = 17;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Queue between the front end and the back end.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Command codes.
    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef enum logic [1:0] {
        KIND_CHECKED  = 2'd0,
        KIND_HEADER   = 2'd1,
        KIND_REJECTED = 2'd2
    } t_result_kind;

    typedef struct packed {
        logic        command;
        logic        page;
        logic [7:0]  data_byte;
        logic [15:0] record_length;
        logic        end_of_stream;
    } t_in_item;

    typedef struct packed {
        t_result_kind result_kind;
        logic         result_page;
        logic         page_valid;
        logic [31:0]  sequence_res;
        logic [31:0]  record_crc;
        logic [15:0]  record_size;
        logic         selected_page;
        logic         partition_empty;
    } t_out_item;

    // One classified item, as the front end hands it to the back end.
    typedef struct packed {
        logic        cmd;
        logic        page;
        logic [7:0]  data_byte;
        logic        start;    // first item of a new stream
        logic        crc_en;   // byte goes into the CRC
        logic        cap_crc;  // byte of the stored CRC word
        logic        cap_seq;  // byte of the sequence word
        logic [1:0]  lane;     // byte lane within a header word
        logic        eos;
        logic        len_ok;   // length and byte count checks passed
        logic [15:0] len16;    // write length on a start, record length on the last item
    } t_op;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_HDR,
        BK_BODY
    } t_back_state;

    // Reflected CRC-32 update by one byte.
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/pingpong_record_validator.sv -----
// Path: an accepted item is written into the queue; the back end takes it from the queue head and
// registers its result in the output register.
// Throughput: one item per cycle while the queue has room. The first item of a write stream holds
// the back end while it starts and the CRC unit folds in the length and sequence words, one
// byte per cycle. A four-entry queue lets the front end keep taking items meanwhile.
// Reset: synchronous, active low; empties the queue, selects page 0, marks it empty, page_size 1024.
`default_nettype none

module pingpong_record_validator import prv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    input  t_in_item    i_in_item,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out_item   o_out_item,
    input  logic        i_out_stall
);

    logic w_q_full;
    logic w_q_push;
    t_op  w_q_op;
    logic w_q_valid;
    t_op  w_q_head;
    logic w_q_pop;

    // Front end: position tracking and item classification.
    prv_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .i_in_item     (i_in_item),
        .o_in_stall    (o_in_stall),
        .i_q_full      (w_q_full),
        .o_q_push      (w_q_push),
        .o_q_op        (w_q_op)
    );

    // Queue of classified items.
    prv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_op    (w_q_op),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_head  (w_q_head),
        .i_pop   (w_q_pop)
    );

    // Back end: CRC, verdicts, page selection and results.
    prv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_head    (w_q_head),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

// ----- hdl/prv_front.sv -----
`default_nettype none

module prv_front import prv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    input  t_in_item    i_in_item,
    output logic        o_in_stall,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_op         o_q_op
);

    logic [15:0]      r_page_size;
    logic             r_active_cmd;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [31:0]      r_len;
    logic [31:0]      n_len;

    logic             w_accept;
    logic             w_start;
    logic [POS_W-1:0] w_p;
    logic [POS_W-1:0] w_pos_inc;
    logic [POS_W-1:0] w_data_idx;
    logic [31:0]      w_len_cur;
    logic [15:0]      w_limit;
    logic [32:0]      w_need;

    // The queue having room is the only condition for taking an item.
    assign o_in_stall = i_q_full;
    assign w_accept   = i_in_valid && !i_q_full;
    assign o_q_push   = w_accept;

    assign w_limit = (r_page_size < MAX_PAGE_BYTES) ? r_page_size : MAX_PAGE_BYTES;

    // Position tracking and classification of the incoming item.
    always_comb begin
        w_start = (r_pos == '0) || (r_active_cmd != i_in_item.command);
        w_p     = w_start ? '0 : r_pos;
        if (w_start) begin
            w_len_cur = (i_in_item.command == CMD_WRITE) ? {16'd0, i_in_item.record_length}
                                                         : 32'd0;
        end else begin
            w_len_cur = r_len;
        end
        w_pos_inc  = (w_p == POS_MAX) ? w_p : w_p + 1'b1;
        w_data_idx = w_p - POS_W'(12);
        n_pos      = i_in_item.end_of_stream ? '0 : w_pos_inc;
        n_len      = w_len_cur;

        o_q_op.cmd       = i_in_item.command;
        o_q_op.page      = i_in_item.page;
        o_q_op.data_byte = i_in_item.data_byte;
        o_q_op.start     = w_start;
        o_q_op.lane      = w_p[1:0];
        o_q_op.eos       = i_in_item.end_of_stream;
        o_q_op.cap_crc   = 1'b0;
        o_q_op.cap_seq   = 1'b0;

        if (i_in_item.command == CMD_CHECK) begin
            // Header bytes 4 to 7 build the length word here.
            if (w_p >= POS_W'(4) && w_p < POS_W'(8)) begin
                n_len = w_len_cur | ({24'd0, i_in_item.data_byte} << {w_p[1:0], 3'b000});
            end
            o_q_op.cap_crc = (w_p < POS_W'(4));
            o_q_op.cap_seq = (w_p >= POS_W'(8)) && (w_p < POS_W'(12));
            o_q_op.crc_en  = ((w_p >= POS_W'(4)) && (w_p < POS_W'(12))) ||
                             ((w_p >= POS_W'(12)) && ({15'd0, w_data_idx} < w_len_cur));
            w_need         = 33'd12 + {1'b0, n_len};
            o_q_op.len_ok  = (n_len <= {16'd0, w_limit}) &&
                             ({16'd0, w_pos_inc} >= w_need);
            o_q_op.len16   = n_len[15:0];
        end else begin
            w_need         = '0;
            o_q_op.crc_en  = ({15'd0, w_p} < w_len_cur);
            o_q_op.len_ok  = (w_len_cur <= {16'd0, w_limit}) &&
                             ({15'd0, w_pos_inc} >= w_len_cur);
            o_q_op.len16   = w_len_cur[15:0];
        end
    end

    // Configuration register and stream position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size  <= PAGE_SIZE_RESET;
            r_active_cmd <= CMD_CHECK;
            r_pos        <= '0;
            r_len        <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_page_size <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_active_cmd <= i_in_item.command;
                r_pos        <= n_pos;
                r_len        <= n_len;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/prv_queue.sv -----
`default_nettype none

module prv_queue import prv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    output logic o_valid,
    output t_op  o_head,
    input  logic i_pop
);

    t_op               r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/prv_back.sv -----
`default_nettype none

module prv_back import prv_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_op       i_q_head,
    output logic      o_q_pop,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    t_back_state r_state;
    t_back_state n_state;
    logic [2:0]  r_hcnt;
    logic [2:0]  n_hcnt;
    logic [31:0] r_crc;
    logic [31:0] n_crc;
    logic [31:0] r_hcrc;
    logic [31:0] n_hcrc;
    logic [31:0] r_hseq;
    logic [31:0] n_hseq;
    logic        r_p0_ok;
    logic        n_p0_ok;
    logic [31:0] r_p0_seq;
    logic [31:0] n_p0_seq;
    logic        r_read_page;
    logic        n_read_page;
    logic [31:0] r_cur_seq;
    logic [31:0] n_cur_seq;
    logic        r_empty;
    logic        n_empty;
    logic        r_out_valid;
    logic        n_out_valid;
    t_out_item   r_out_item;
    t_out_item   n_out_item;

    logic        w_out_free;
    logic [31:0] w_seq_inc;
    logic [31:0] w_hdr_word;
    logic [7:0]  w_hdr_byte;
    logic [31:0] w_crc_base;
    logic [31:0] w_crc_new;
    logic [31:0] w_hcrc_new;
    logic [31:0] w_hseq_new;
    logic [31:0] w_crc_out;
    logic        w_valid;
    logic        w_reject;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_seq_inc   = r_cur_seq + 32'd1;

    // Header bytes of a write: length word, then the next sequence word.
    assign w_hdr_word = r_hcnt[2] ? w_seq_inc : {16'd0, i_q_head.len16};
    assign w_hdr_byte = 8'(w_hdr_word >> {r_hcnt[1:0], 3'b000});

    // Datapath for the item at the head of the queue.
    always_comb begin
        w_crc_base = (i_q_head.start && r_state == BK_RUN) ? ALL_ONES : r_crc;
        w_crc_new  = i_q_head.crc_en ? crc_byte(w_crc_base, i_q_head.data_byte) : w_crc_base;
        w_hcrc_new = i_q_head.start ? 32'd0 : r_hcrc;
        w_hseq_new = i_q_head.start ? 32'd0 : r_hseq;
        if (i_q_head.cap_crc) begin
            w_hcrc_new = w_hcrc_new |
                         ({24'd0, i_q_head.data_byte} << {i_q_head.lane, 3'b000});
        end
        if (i_q_head.cap_seq) begin
            w_hseq_new = w_hseq_new |
                         ({24'd0, i_q_head.data_byte} << {i_q_head.lane, 3'b000});
        end
        w_crc_out = ~w_crc_new;
        w_valid   = i_q_head.len_ok && (w_hcrc_new != ALL_ONES) &&
                    (w_hseq_new != ALL_ONES) && (w_hcrc_new == w_crc_out);
        w_reject  = !i_q_head.len_ok || (r_cur_seq >= SEQ_LAST);
    end

    // Sequencer, selection and result formation.
    always_comb begin
        n_state     = r_state;
        n_hcnt      = r_hcnt;
        n_crc       = r_crc;
        n_hcrc      = r_hcrc;
        n_hseq      = r_hseq;
        n_p0_ok     = r_p0_ok;
        n_p0_seq    = r_p0_seq;
        n_read_page = r_read_page;
        n_cur_seq   = r_cur_seq;
        n_empty     = r_empty;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        o_q_pop     = 1'b0;

        case (r_state)
            BK_RUN, BK_BODY: begin
                if (i_q_valid) begin
                    if (r_state == BK_RUN && i_q_head.start && i_q_head.cmd == CMD_WRITE) begin
                        // A new write first folds its header words into the CRC.
                        n_state = BK_HDR;
                        n_hcnt  = '0;
                        n_crc   = ALL_ONES;
                    end else if (!i_q_head.eos || w_out_free) begin
                        o_q_pop = 1'b1;
                        n_state = BK_RUN;
                        n_crc   = w_crc_new;
                        n_hcrc  = w_hcrc_new;
                        n_hseq  = w_hseq_new;
                        if (i_q_head.eos) begin
                            n_out_valid            = 1'b1;
                            n_out_item.record_size = i_q_head.len16;
                            if (i_q_head.cmd == CMD_CHECK) begin
                                if (!i_q_head.page) begin
                                    n_p0_ok  = w_valid;
                                    n_p0_seq = w_hseq_new;
                                end else begin
                                    n_empty = 1'b0;
                                    if (w_valid && (!r_p0_ok || w_hseq_new > r_p0_seq)) begin
                                        n_read_page = 1'b1;
                                        n_cur_seq   = w_hseq_new;
                                    end else if (r_p0_ok) begin
                                        n_read_page = 1'b0;
                                        n_cur_seq   = r_p0_seq;
                                    end else begin
                                        n_read_page = 1'b0;
                                        n_cur_seq   = '0;
                                        n_empty     = 1'b1;
                                    end
                                end
                                n_out_item.result_kind  = KIND_CHECKED;
                                n_out_item.result_page  = i_q_head.page;
                                n_out_item.page_valid   = w_valid;
                                n_out_item.sequence_res = w_hseq_new;
                                n_out_item.record_crc   = w_crc_out;
                            end else begin
                                n_out_item.result_page = !r_read_page;
                                n_out_item.page_valid  = 1'b0;
                                if (w_reject) begin
                                    n_out_item.result_kind  = KIND_REJECTED;
                                    n_out_item.sequence_res = '0;
                                    n_out_item.record_crc   = '0;
                                end else begin
                                    n_cur_seq               = w_seq_inc;
                                    n_read_page             = !r_read_page;
                                    n_empty                 = 1'b0;
                                    n_out_item.result_kind  = KIND_HEADER;
                                    n_out_item.sequence_res = w_seq_inc;
                                    n_out_item.record_crc   = w_crc_out;
                                end
                            end
                            n_out_item.selected_page   = n_read_page;
                            n_out_item.partition_empty = n_empty;
                        end
                    end
                end
            end
            BK_HDR: begin
                n_crc  = crc_byte(r_crc, w_hdr_byte);
                n_hcnt = r_hcnt + 1'b1;
                if (r_hcnt == 3'd7) begin
                    n_state = BK_BODY;
                end
            end
            default: begin
                n_state = BK_RUN;
            end
        endcase
    end

    // Control and selection state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_RUN;
            r_hcnt      <= '0;
            r_crc       <= ALL_ONES;
            r_hcrc      <= '0;
            r_hseq      <= '0;
            r_p0_ok     <= 1'b0;
            r_p0_seq    <= '0;
            r_read_page <= 1'b0;
            r_cur_seq   <= '0;
            r_empty     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hcnt      <= n_hcnt;
            r_crc       <= n_crc;
            r_hcrc      <= n_hcrc;
            r_hseq      <= n_hseq;
            r_p0_ok     <= n_p0_ok;
            r_p0_seq    <= n_p0_seq;
            r_read_page <= n_read_page;
            r_cur_seq   <= n_cur_seq;
            r_empty     <= n_empty;
            r_out_valid <= n_out_valid;
        end
    end

    // Output item register.
    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

endmodule

`default_nettype wire

// ----- hdl/prv_checker.sv -----
`default_nettype none

module prv_checker import prv_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input t_out_item o_out_item,
    input logic      i_out_stall
);

    // A stalled result item stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    // A rejected write carries no sequence, CRC or verdict.
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.result_kind == KIND_REJECTED |->
        o_out_item.sequence_res == '0 && o_out_item.record_crc == '0 &&
        !o_out_item.page_valid)
        else $error("rejected write carries data");

    // An accepted write makes its target page current and the partition non-empty.
    a_header_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.result_kind == KIND_HEADER |->
        !o_out_item.partition_empty &&
        o_out_item.selected_page == o_out_item.result_page &&
        o_out_item.sequence_res != ALL_ONES)
        else $error("write header inconsistent with selection");

    // A valid page 1 always leaves the partition non-empty.
    a_check_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.result_kind == KIND_CHECKED &&
        o_out_item.result_page && o_out_item.page_valid |->
        !o_out_item.partition_empty)
        else $error("valid page 1 left partition empty");

endmodule

bind pingpong_record_validator prv_checker u_prv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);

`default_nettype wire

// ----- bench/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import prv_pkg::*;

    typedef enum {FLAW_NONE, FLAW_BAD_CRC, FLAW_CRC_ONES} t_flaw;

    // Clock and synchronous reset.
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #6 clk = ~clk;

    // Block inputs, all known from time zero.
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid    = 1'b0;
    t_in_item    in_item     = '0;
    logic        out_stall   = 1'b0;

    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_item;

    pingpong_record_validator u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_item     (in_item),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .o_out_item    (o_out_item),
        .i_out_stall   (out_stall)
    );

    // Items waiting to be sent and headers or verdicts waiting to come out.
    t_in_item    pending_q[$];
    t_out_item   results_due[$];
    int unsigned send_gap   = 0;
    int unsigned stall_left = 0;
    logic        calm  = 1'b0;  // no idling on either side while set
    int          fails = 0;

    // Partition state as the predictor sees it.
    logic [15:0]      size_reg = PAGE_SIZE_RESET;
    logic [31:0]      crc_acc  = ALL_ONES;
    logic [POS_W-1:0] pos      = '0;
    logic [31:0]      hdr_crc  = '0;
    logic [31:0]      hdr_len  = '0;
    logic [31:0]      hdr_seq  = '0;
    logic [31:0]      p0_seq   = '0;
    logic             p0_ok    = 1'b0;
    logic             sel_page = 1'b0;
    logic [31:0]      cur_seq  = '0;
    logic             empty    = 1'b1;
    logic             act_cmd  = CMD_CHECK;

    // Reflected CRC-32, one input bit at a time.
    function automatic logic [31:0] crc_fold8(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        logic        fb;
        r = c;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ b[i];
            r  = {1'b0, r[31:1]} ^ (fb ? CRC_POLY : 32'd0);
        end
        return r;
    endfunction

    function automatic logic [31:0] crc_fold32(input logic [31:0] c, input logic [31:0] w);
        logic [31:0] r;
        r = c;
        for (int i = 0; i < 4; i++) begin
            r = crc_fold8(r, w[8*i +: 8]);
        end
        return r;
    endfunction

    task automatic restart_stream();
        crc_acc = ALL_ONES;
        pos     = '0;
        hdr_crc = '0;
        hdr_len = '0;
        hdr_seq = '0;
    endtask

    // Folds one accepted item into the partition state and queues the result it causes.
    task automatic advance_partition(input t_in_item it);
        logic [31:0] n;
        logic [31:0] lim;
        logic        ok;
        t_out_item   res;
        if (pos != 0 && act_cmd != it.command) begin
            restart_stream();
        end
        if (pos == 0) begin
            restart_stream();
            act_cmd = it.command;
            if (it.command == CMD_WRITE) begin
                hdr_len = {16'd0, it.record_length};
                crc_acc = crc_fold32(crc_fold32(crc_acc, hdr_len), cur_seq + 32'd1);
            end
        end

        // Header words are little-endian; only length, sequence and data enter the CRC.
        if (it.command == CMD_CHECK) begin
            if (pos < 4) begin
                hdr_crc[8*pos[1:0] +: 8] = it.data_byte;
            end else if (pos < 8) begin
                hdr_len[8*pos[1:0] +: 8] = it.data_byte;
                crc_acc = crc_fold8(crc_acc, it.data_byte);
            end else if (pos < 12) begin
                hdr_seq[8*pos[1:0] +: 8] = it.data_byte;
                crc_acc = crc_fold8(crc_acc, it.data_byte);
            end else if (32'(pos) - 32'd12 < hdr_len) begin
                crc_acc = crc_fold8(crc_acc, it.data_byte);
            end
        end else if (32'(pos) < hdr_len) begin
            crc_acc = crc_fold8(crc_acc, it.data_byte);
        end
        if (pos != POS_MAX) begin
            pos = pos + 1'b1;
        end

        if (it.end_of_stream) begin
            n   = 32'(pos);
            lim = (size_reg < MAX_PAGE_BYTES) ? 32'(size_reg) : 32'(MAX_PAGE_BYTES);
            res = '0;
            res.record_size = hdr_len[15:0];
            if (it.command == CMD_CHECK) begin
                ok = hdr_crc != ALL_ONES && hdr_len != ALL_ONES && hdr_seq != ALL_ONES &&
                     hdr_len <= lim && {32'd0, n} >= {32'd0, hdr_len} + 64'd12 &&
                     hdr_crc == ~crc_acc;
                if (it.page == 1'b0) begin
                    p0_ok  = ok;
                    p0_seq = hdr_seq;
                end else begin
                    // Newer valid page wins; page 0 keeps a tie.
                    empty = 1'b0;
                    if (ok && (!p0_ok || hdr_seq > p0_seq)) begin
                        sel_page = 1'b1;
                        cur_seq  = hdr_seq;
                    end else if (p0_ok) begin
                        sel_page = 1'b0;
                        cur_seq  = p0_seq;
                    end else begin
                        sel_page = 1'b0;
                        cur_seq  = '0;
                        empty    = 1'b1;
                    end
                end
                res.result_kind  = KIND_CHECKED;
                res.result_page  = it.page;
                res.page_valid   = ok;
                res.sequence_res = hdr_seq;
                res.record_crc   = ~crc_acc;
            end else begin
                res.result_page = ~sel_page;
                if (hdr_len > lim || n < hdr_len || cur_seq >= SEQ_LAST) begin
                    res.result_kind = KIND_REJECTED;
                end else begin
                    cur_seq          = cur_seq + 32'd1;
                    sel_page         = ~sel_page;
                    empty            = 1'b0;
                    res.result_kind  = KIND_HEADER;
                    res.sequence_res = cur_seq;
                    res.record_crc   = ~crc_acc;
                end
            end
            res.selected_page   = sel_page;
            res.partition_empty = empty;
            results_due.push_back(res);
            restart_stream();
        end
    endtask

    // Sender: one item per handshake, with a random gap after each one.
    always @(posedge clk) begin : drive
        int unsigned gap;
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else if (in_valid && !o_in_stall) begin
            advance_partition(in_item);
            if ($urandom_range(0, 39) == 0) begin
                calm <= !calm;
            end
            gap = calm ? 0 : $urandom_range(0, 4);
            if (gap == 0 && pending_q.size() != 0) begin
                in_item <= pending_q.pop_front();
            end else begin
                in_valid <= 1'b0;
                send_gap <= (gap == 0) ? 0 : gap - 1;
            end
        end else if (!in_valid) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_q.size() != 0) begin
                in_item  <= pending_q.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endtask

    // Receiver: compares each result with the oldest expectation, stalls at random.
    always @(posedge clk) begin : observe
        t_out_item   want;
        int unsigned w;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (o_out_valid && !out_stall) begin
            if (results_due.size() == 0) begin
                $error("result_kind: expected no item, got %0d", o_out_item.result_kind);
                fails++;
            end else begin
                want = results_due.pop_front();
                check_field("result_kind", 32'(want.result_kind), 32'(o_out_item.result_kind));
                check_field("result_page", 32'(want.result_page), 32'(o_out_item.result_page));
                check_field("page_valid", 32'(want.page_valid), 32'(o_out_item.page_valid));
                check_field("sequence_res", want.sequence_res, o_out_item.sequence_res);
                check_field("record_crc", want.record_crc, o_out_item.record_crc);
                check_field("record_size", 32'(want.record_size), 32'(o_out_item.record_size));
                check_field("selected_page", 32'(want.selected_page),
                            32'(o_out_item.selected_page));
                check_field("partition_empty", 32'(want.partition_empty),
                            32'(o_out_item.partition_empty));
            end
            w = calm ? 0 : $urandom_range(0, 4);
            out_stall  <= (w != 0);
            stall_left <= w;
        end else if (out_stall) begin
            if (stall_left <= 1) begin
                out_stall <= 1'b0;
            end else begin
                stall_left <= stall_left - 1;
            end
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            // Stall ahead of a result so that the first cycle of a valid gets hit too.
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(1, 4);
        end
    end

    task automatic queue_byte(input logic cmd, input logic pg, input logic [7:0] b,
                              input logic [15:0] rlen, input logic eos);
        t_in_item it;
        it.command       = cmd;
        it.page          = pg;
        it.data_byte     = b;
        it.record_length = rlen;
        it.end_of_stream = eos;
        pending_q.push_back(it);
    endtask

    // Streams a page image of total_n bytes: header, then random data.
    task automatic queue_page(input logic pg, input logic [31:0] len_word,
                              input logic [31:0] seq, input t_flaw flaw, input int total_n);
        logic [7:0]  body[$];
        logic [31:0] c;
        logic [31:0] stored;
        logic [7:0]  b;
        int          dn;
        dn = (total_n > 12) ? total_n - 12 : 0;
        c  = crc_fold32(crc_fold32(ALL_ONES, len_word), seq);
        for (int i = 0; i < dn; i++) begin
            body.push_back(8'($urandom));
            if (i < len_word) begin
                c = crc_fold8(c, body[i]);
            end
        end
        case (flaw)
            FLAW_BAD_CRC:  stored = ~c ^ (32'd1 << $urandom_range(0, 31));
            FLAW_CRC_ONES: stored = ALL_ONES;
            default:       stored = ~c;
        endcase
        for (int i = 0; i < total_n; i++) begin
            if (i < 4) begin
                b = stored[8*i +: 8];
            end else if (i < 8) begin
                b = len_word[8*(i-4) +: 8];
            end else if (i < 12) begin
                b = seq[8*(i-8) +: 8];
            end else begin
                b = body[i-12];
            end
            queue_byte(CMD_CHECK, (i == total_n - 1) ? pg : 1'($urandom), b,
                       16'($urandom), i == total_n - 1);
        end
    endtask

    // The length travels on the first byte; later bytes mostly repeat it.
    task automatic queue_write(input logic [15:0] len, input int total_n);
        for (int i = 0; i < total_n; i++) begin
            queue_byte(CMD_WRITE, 1'($urandom), 8'($urandom),
                       (i == 0 || $urandom_range(0, 3) != 0) ? len : 16'($urandom),
                       i == total_n - 1);
        end
    endtask

    function automatic logic [31:0] pick_seq(input logic [31:0] near);
        case ($urandom_range(0, 7))
            0, 1:    return $urandom;
            2, 3:    return $urandom_range(0, 20);
            4:       return near;
            5:       return near + 32'd1;
            6:       return SEQ_LAST - 32'($urandom_range(0, 2));
            default: return ($urandom_range(0, 3) == 0) ? ALL_ONES : 32'($urandom_range(0, 20));
        endcase
    endfunction

    function automatic t_flaw pick_flaw();
        case ($urandom_range(0, 19))
            0, 1:    return FLAW_BAD_CRC;
            2:       return FLAW_CRC_ONES;
            default: return FLAW_NONE;
        endcase
    endfunction

    function automatic int draw_len();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
    endfunction

    // Mostly the exact image length, sometimes truncated or padded.
    function automatic int page_span(input int len);
        case ($urandom_range(0, 9))
            0:       return $urandom_range(1, 11 + len);
            1:       return 12 + len + $urandom_range(1, 5);
            default: return 12 + len;
        endcase
    endfunction

    // Mostly well-formed page pairs and writes, plus broken streams and noise.
    task automatic queue_random_stream();
        int          len;
        logic [31:0] s0;
        len = draw_len();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                s0 = pick_seq(cur_seq);
                queue_page(1'b0, 32'(len), s0, pick_flaw(), page_span(len));
                len = draw_len();
                queue_page(1'b1, 32'(len), pick_seq(s0), pick_flaw(), page_span(len));
            end
            4: queue_page(1'($urandom), 32'(len), pick_seq(cur_seq), pick_flaw(),
                          page_span(len));
            5, 6, 7: queue_write(16'(len), (len == 0) ? 1 : len);
            8: begin
                case ($urandom_range(0, 2))
                    0:       queue_write(16'(len + 2), $urandom_range(1, len + 1));
                    1:       queue_write(16'(len), len + $urandom_range(1, 4));
                    default: queue_write(16'($urandom), $urandom_range(1, 3));
                endcase
            end
            default: begin
                repeat ($urandom_range(1, 6)) begin
                    queue_byte(1'($urandom), 1'($urandom), 8'($urandom), 16'($urandom),
                               $urandom_range(0, 7) == 0);
                end
            end
        endcase
    endtask

    // Waits until everything sent has been answered, then lets the back end settle.
    task automatic wait_idle();
        do begin
            @(negedge clk);
        end while (pending_q.size() != 0 || in_valid || results_due.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_page_size(input logic [15:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        size_reg = v;
    endtask

    // Stimulus: directed cases, then random phases under several page sizes.
    initial begin : stimulus
        logic [15:0] sizes[5];
        int          mark;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Selection: newer page 1, tie kept by page 0, both invalid.
        queue_page(1'b0, 32'd2, 32'd5, FLAW_NONE, 14);
        queue_page(1'b1, 32'd0, 32'd7, FLAW_NONE, 12);
        queue_page(1'b1, 32'd3, 32'd5, FLAW_NONE, 15);
        queue_page(1'b0, 32'd1, 32'd9, FLAW_BAD_CRC, 13);
        queue_page(1'b1, 32'd1, 32'd9, FLAW_CRC_ONES, 13);
        // Writes: zero length, exact, short, excess bytes, too long.
        queue_write(16'd0, 1);
        queue_write(16'd3, 3);
        queue_write(16'd3, 2);
        queue_write(16'd2, 6);
        queue_write(16'hFFFF, 1);
        // Header words of all ones, a truncated page and one with trailing bytes.
        queue_page(1'b0, ALL_ONES, 32'd4, FLAW_NONE, 16);
        queue_page(1'b1, 32'd0, ALL_ONES, FLAW_NONE, 12);
        queue_page(1'b1, 32'd2, 32'd3, FLAW_NONE, 9);
        queue_page(1'b1, 32'd2, 32'd3, FLAW_NONE, 19);
        // A change of command abandons the stream in progress.
        repeat (5) queue_byte(CMD_CHECK, 1'($urandom), 8'($urandom), 16'($urandom), 1'b0);
        queue_write(16'd2, 2);
        repeat (2) queue_byte(CMD_WRITE, 1'($urandom), 8'($urandom), 16'd4, 1'b0);
        queue_page(1'b0, 32'd1, 32'd6, FLAW_NONE, 13);
        // Sequence at the top of its range: one more write, then rejection.
        queue_page(1'b0, 32'd0, 32'd1, FLAW_BAD_CRC, 12);
        queue_page(1'b1, 32'd0, SEQ_LAST - 32'd1, FLAW_NONE, 12);
        queue_write(16'd1, 1);
        queue_write(16'd1, 1);
        queue_page(1'b1, 32'd4, SEQ_LAST, FLAW_NONE, 16);
        queue_write(16'd0, 1);
        queue_page(1'b1, 32'd0, 32'd0, FLAW_NONE, 12);
        wait_idle();

        sizes[0] = 16'd0;
        sizes[1] = 16'hFFFF;
        sizes[2] = 16'($urandom_range(1, 12));
        sizes[3] = 16'($urandom_range(1, 12));
        sizes[4] = MAX_PAGE_BYTES;
        for (int p = 0; p < 5; p++) begin
            set_page_size(sizes[p]);
            mark = pending_q.size();
            while (pending_q.size() < mark + 45) begin
                queue_random_stream();
            end
            // Close any stream left open by noise.
            queue_byte(CMD_CHECK, 1'($urandom), 8'($urandom), 16'($urandom), 1'b1);
            wait_idle();
        end

        if (fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin : watchdog
        #(2_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
